### sv/xnpc_pkg.sv
// Shared types, constants and helpers for the XNOR/popcount neuron batch.
// No dependencies; imported by every module of the block.
package xnpc_pkg;

    localparam int VALUE_W    = 32;   // activation / weight word
    localparam int NEURON_W   = 5;
    localparam int WIDX_W     = 6;
    localparam int WORD_W     = 7;    // word counter and length register
    localparam int CNT_W      = 12;   // match counts and threshold
    localparam int PC_W       = 6;    // popcount of one 32-bit word
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 12;

    localparam logic [CNT_W-1:0]  CNT_MAX       = 12'd4095;
    localparam logic [WORD_W-1:0] LEN_RESET     = 7'd64;
    localparam logic [CNT_W-1:0]  THR_RESET     = 12'd35;

    // result queue: bounds the number of outstanding results
    localparam int RES_DEPTH  = 4;
    localparam int RES_PTR_W  = $clog2(RES_DEPTH);
    localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_INPUT_WORDS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 1'b1;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_DATA = 1'b1
    } t_op;

    // one transaction as it travels down the cell chain
    typedef struct packed {
        t_op                 op;
        logic                en;     // load in range / data word within store
        logic                last;   // data word that closes the inference
        logic [NEURON_W-1:0] neuron;
        logic [WORD_W-1:0]   word;   // weight address
        logic [VALUE_W-1:0]  value;
        logic [VALUE_W-1:0]  fired;  // result bits gathered so far
    } t_item;

    function automatic logic [PC_W-1:0] ones_in(input logic [VALUE_W-1:0] x);
        logic [PC_W-1:0] s;
        s = '0;
        for (int i = 0; i < VALUE_W; i++) begin
            s = s + PC_W'(x[i]);
        end
        return s;
    endfunction

endpackage

### sv/xnor_popcount_neuron_batch.sv
// Top level of the XNOR/popcount binary neuron batch: word counter, config
// registers, a chain of NEURONS cells and the result queue.
// Depends on xnpc_pkg, xnpc_cell and xnpc_res_fifo.
//  - Input channel (i_valid / o_stall): i_opcode = 0 loads i_value as the weight
//    word of neuron i_neuron at position i_word_index; i_opcode = 1 feeds one
//    32-bit activation word of the current inference.
//  - Output channel (o_valid / i_stall): one o_out_bits word per inference,
//    bit j set when neuron j's match count is strictly above threshold.
//  - Config port: i_cfg_we with i_cfg_idx 0 writes input_words, 1 writes
//    threshold. Write only while the block is idle.
//  - Each transaction walks down the chain one cell per cycle, so loads and
//    data words are taken at one per cycle while o_stall is low.
//  - Each cell holds a transaction in one register stage; a closing data word's
//    result is then written into the result queue, which raises o_valid.
//  - At most RES_DEPTH (4) results may be in flight or queued; o_stall is high
//    while that many are outstanding.
//  - Receiver stall: results wait in the queue; inputs flow until that limit.
//  - Reset: counters, word count and queue clear; input_words = 64,
//    threshold = 35. Weight memories are not cleared and must be loaded.
module xnor_popcount_neuron_batch
    import xnpc_pkg::*;
#(
    parameter int NEURONS   = 32,
    parameter int MAX_WORDS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input channel
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic                  i_opcode,
    input  logic [NEURON_W-1:0]   i_neuron,
    input  logic [WIDX_W-1:0]     i_word_index,
    input  logic [VALUE_W-1:0]    i_value,
    // output channel
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [VALUE_W-1:0]    o_out_bits,
    // config port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    // config registers
    logic [WORD_W-1:0]    r_input_words;
    logic [CNT_W-1:0]     r_threshold;

    // inference bookkeeping
    logic [WORD_W-1:0]    r_words_seen;
    logic [WORD_W-1:0]    n_words_seen;
    logic [RES_CNT_W-1:0] r_pend;
    logic [RES_CNT_W-1:0] n_pend;

    logic                 in_acc;
    logic                 out_acc;
    logic [WORD_W-1:0]    eff_len;
    logic [WORD_W-1:0]    seen_inc;
    t_item                head;

    // chain wiring: stage 0 is the input, stage NEURONS the chain tail
    logic                 w_vld  [NEURONS+1];
    t_item                w_item [NEURONS+1];
    logic                 res_push;

    assign o_stall = (int'(r_pend) == RES_DEPTH);
    assign in_acc  = i_valid && !o_stall;
    assign out_acc = o_valid && !i_stall;

    // effective length: zero acts as one, clamp to the store depth
    always_comb begin
        if (r_input_words == '0) begin
            eff_len = WORD_W'(1);
        end else if (int'(r_input_words) > MAX_WORDS) begin
            eff_len = WORD_W'(MAX_WORDS);
        end else begin
            eff_len = r_input_words;
        end
    end

    assign seen_inc = r_words_seen + WORD_W'(1);

    // build the transaction entering the chain
    always_comb begin
        head        = '0;
        head.op     = t_op'(i_opcode);
        head.neuron = i_neuron;
        head.value  = i_value;
        head.fired  = '0;
        if (t_op'(i_opcode) == OP_LOAD) begin
            head.word = WORD_W'(i_word_index);
            head.en   = (int'(i_neuron) < NEURONS) && (int'(i_word_index) < MAX_WORDS);
            head.last = 1'b0;
        end else begin
            head.word = r_words_seen;
            head.en   = int'(r_words_seen) < MAX_WORDS;
            head.last = seen_inc >= eff_len;
        end
    end

    always_comb begin
        n_words_seen = r_words_seen;
        if (in_acc && (head.op == OP_DATA)) begin
            n_words_seen = head.last ? '0 : seen_inc;
        end
        n_pend = r_pend + RES_CNT_W'(in_acc && (head.op == OP_DATA) && head.last)
                        - RES_CNT_W'(out_acc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_input_words <= LEN_RESET;
            r_threshold   <= THR_RESET;
            r_words_seen  <= '0;
            r_pend        <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_INPUT_WORDS: r_input_words <= i_cfg_data[WORD_W-1:0];
                    REG_THRESHOLD:   r_threshold   <= i_cfg_data[CNT_W-1:0];
                    default:         r_threshold   <= r_threshold;
                endcase
            end
            r_words_seen <= n_words_seen;
            r_pend       <= n_pend;
        end
    end

    assign w_vld[0]  = in_acc;
    assign w_item[0] = head;

    for (genvar g = 0; g < NEURONS; g++) begin : g_cell
        xnpc_cell #(
            .CELL_ID   (g),
            .MAX_WORDS (MAX_WORDS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_vld[g]),
            .i_item  (w_item[g]),
            .i_thr   (r_threshold),
            .o_vld   (w_vld[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    // only closing data words carry a result out of the chain
    assign res_push = w_vld[NEURONS] && (w_item[NEURONS].op == OP_DATA)
                      && w_item[NEURONS].last;

    xnpc_res_fifo u_res_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (w_item[NEURONS].fired),
        .i_pop   (!i_stall),
        .o_valid (o_valid),
        .o_data  (o_out_bits)
    );

endmodule

### sv/xnpc_cell.sv
// One neuron cell: weight memory, match counter and threshold compare.
// Depends on xnpc_pkg; chained by xnor_popcount_neuron_batch.
module xnpc_cell
    import xnpc_pkg::*;
#(
    parameter int CELL_ID   = 0,
    parameter int MAX_WORDS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  t_item            i_item,
    input  logic [CNT_W-1:0] i_thr,
    output logic             o_vld,
    output t_item            o_item
);

    localparam int AW = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam logic [VALUE_W-1:0] FIRE_MASK =
        (CELL_ID < VALUE_W) ? (VALUE_W'(1) << CELL_ID) : '0;

    logic [VALUE_W-1:0] mem [MAX_WORDS];

    logic               r_vld;
    t_item              r_item;
    logic [VALUE_W-1:0] r_rdata;
    logic [CNT_W-1:0]   r_acc;
    logic [CNT_W-1:0]   n_acc;

    logic [AW-1:0]      addr;
    logic               wr_en;
    logic [PC_W-1:0]    pc;
    logic [CNT_W:0]     sum;
    logic [CNT_W-1:0]   acc_upd;
    logic               is_data;
    logic               fire;

    assign addr  = AW'(i_item.word);
    assign wr_en = i_vld && (i_item.op == OP_LOAD) && i_item.en
                   && (int'(i_item.neuron) == CELL_ID);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[addr] <= i_item.value;
        end
        if (i_vld) begin
            r_rdata <= mem[addr];
            r_item  <= i_item;
        end
    end

    assign is_data = r_vld && (r_item.op == OP_DATA);
    assign pc      = ones_in(~(r_item.value ^ r_rdata));
    assign sum     = {1'b0, r_acc} + (CNT_W + 1)'(pc);

    always_comb begin
        acc_upd = r_acc;
        if (is_data && r_item.en) begin
            acc_upd = sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
        end
        fire  = acc_upd > i_thr;
        n_acc = (is_data && r_item.last) ? '0 : acc_upd;

        o_item = r_item;
        if (is_data && r_item.last && fire) begin
            o_item.fired = r_item.fired | FIRE_MASK;
        end
    end

    assign o_vld = r_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_acc <= '0;
        end else begin
            r_vld <= i_vld;
            r_acc <= n_acc;
        end
    end

endmodule

### sv/xnpc_res_fifo.sv
// Small result queue at the end of the cell chain.
// Depends on xnpc_pkg for depth and word width.
module xnpc_res_fifo
    import xnpc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  logic [VALUE_W-1:0] i_data,
    input  logic               i_pop,
    output logic               o_valid,
    output logic [VALUE_W-1:0] o_data
);

    logic [VALUE_W-1:0]   r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wr;
    logic [RES_PTR_W-1:0] r_rd;
    logic [RES_CNT_W-1:0] r_cnt;
    logic                 do_pop;

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (int'(r_wr) == RES_DEPTH - 1) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (int'(r_rd) == RES_DEPTH - 1) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + RES_CNT_W'(i_push) - RES_CNT_W'(do_pop);
        end
    end

endmodule

### sv/xnpc_checker.sv
// Port-level checks for xnor_popcount_neuron_batch, attached by bind.
// Depends on xnpc_pkg for port widths.
module xnpc_checker
    import xnpc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  o_stall,
    input logic                  o_valid,
    input logic                  i_stall,
    input logic [VALUE_W-1:0]    o_out_bits
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid)
        else $error("result dropped while stalled");

    // and its word does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> $stable(o_out_bits))
        else $error("result word changed while stalled");

    // reset empties the queue and frees the input side
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("queue or stall not cleared by reset");

endmodule

bind xnor_popcount_neuron_batch xnpc_checker u_xnpc_checker (.*);
